FILE: design/crdo_pkg.sv
package crdo_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned REG_COUNT  = 17;
   localparam int unsigned RIDX_WIDTH = $clog2(REG_COUNT);

   // Register file slots: D0..D7, A0..A6, user SP, supervisor SP
   localparam logic [RIDX_WIDTH-1:0] AREG_BASE = RIDX_WIDTH'(8);
   localparam logic [RIDX_WIDTH-1:0] USP_SLOT  = RIDX_WIDTH'(15);
   localparam logic [RIDX_WIDTH-1:0] SSP_SLOT  = RIDX_WIDTH'(16);
   localparam logic [2:0]            SP_REG    = 3'd7;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [RIDX_WIDTH-1:0] ridx_type;

   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_ADD   = 3'd2,
      OP_OR    = 3'd3,
      OP_SUB   = 3'd4,
      OP_NOT   = 3'd5,
      OP_SUBQ  = 3'd6,
      OP_BTST  = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      SZ_BYTE = 2'd0,
      SZ_WORD = 2'd1,
      SZ_LONG = 2'd2,
      SZ_ALT  = 2'd3
   } size_type;

   typedef struct packed {
      logic       supervisor;
      word_type   operand;
      size_type   size_code;
      logic [2:0] reg_index;
      logic       is_address;
      opcode_type opcode;
   } item_type;

   typedef struct packed {
      logic     zero_flag;
      word_type reg_value;
   } result_type;

   typedef struct packed {
      logic     wr_en;
      word_type wr_data;
   } update_type;

   function automatic word_type size_mask(input size_type sz);
      word_type m;
      unique case (sz)
         SZ_BYTE: m = 32'h0000_00FF;
         SZ_WORD: m = 32'h0000_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic word_type sign_ext(input word_type v, input size_type sz);
      word_type r;
      unique case (sz)
         SZ_BYTE: r = v[7]  ? (v | 32'hFFFF_FF00) : (v & 32'h0000_00FF);
         SZ_WORD: r = v[15] ? (v | 32'hFFFF_0000) : (v & 32'h0000_FFFF);
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

FILE: design/crdo_regfile.sv
module crdo_regfile (
   input  logic               clock,
   input  logic               reset,
   input  crdo_pkg::ridx_type rd_idx,
   output crdo_pkg::word_type rd_data,
   input  crdo_pkg::ridx_type wr_idx,
   input  crdo_pkg::update_type upd
);
   import crdo_pkg::*;

   word_type regs_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (upd.wr_en) begin
         regs_ff[wr_idx] <= upd.wr_data;
      end
   end

   assign rd_data = regs_ff[rd_idx];

endmodule

FILE: design/crdo_alu.sv
module crdo_alu (
   input  crdo_pkg::item_type   item,
   input  crdo_pkg::word_type   cur,
   output crdo_pkg::update_type upd,
   output crdo_pkg::result_type res
);
   import crdo_pkg::*;

   word_type m;
   word_type quick;
   word_type sub_b;
   word_type diff;
   word_type nv;
   logic     zf;

   always_comb begin
      m     = size_mask(item.size_code);
      quick = {24'd0, item.operand[7:0]};
      // one subtractor shared by sub and subq
      if (item.opcode == OP_SUBQ) begin
         sub_b = quick;
      end else if (item.is_address) begin
         sub_b = sign_ext(item.operand, item.size_code);
      end else begin
         sub_b = item.operand;
      end
      diff = cur - sub_b;
      nv   = cur;
      zf   = 1'b0;

      unique case (item.opcode)
         OP_READ: nv = cur;
         OP_WRITE: begin
            if (item.is_address && item.size_code == SZ_WORD) begin
               nv = sign_ext(item.operand, SZ_WORD);
            end else begin
               nv = (cur & ~m) | (item.operand & m);
            end
         end
         OP_ADD: nv = cur + item.operand;
         OP_OR:  nv = cur | (item.operand & m);
         OP_SUB, OP_SUBQ: begin
            if (item.is_address) begin
               nv = diff;
            end else begin
               nv = (cur & ~m) | (diff & m);
            end
         end
         OP_NOT: nv = (cur & ~m) | (~cur & m);
         OP_BTST: zf = ~cur[item.operand[4:0]];
         default: nv = cur;
      endcase

      upd.wr_en   = (item.opcode != OP_READ) && (item.opcode != OP_BTST);
      upd.wr_data = nv;
      res.reg_value = (item.opcode == OP_READ) ? (cur & m) : nv;
      res.zero_flag = zf;
   end

endmodule

FILE: design/cpu_register_direct_operand_unit.sv
// Register-direct operand unit: D0-D7, A0-A6, user and supervisor SP.
// A request beat reaches the response beat through the input register, then the
// register-file read, ALU merge and write-back, and the result register.
// Throughput: 1 beat per cycle while rsp_tready stays high; a beat reads the register
// file after the previous beat's write-back, so back-to-back beats on one register chain.
// Reset (synchronous, active high) zeroes all 17 registers and empties both stages.
module cpu_register_direct_operand_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [2:0] opcode, [3] is_address, [6:4] reg_index,
   //            [8:7] size_code, [40:9] operand, [41] supervisor, [47:42] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: [31:0] reg_value, [32] zero_flag, [39:33] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);
   import crdo_pkg::*;

   // input stage
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;

   // result stage
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;

   logic       advance;
   ridx_type   slot;
   word_type   cur;
   update_type upd;
   update_type upd_gated;
   result_type res;

   // the input stage moves on when the result register is free or drains now
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= item_type'(req_tdata[41:0]);
      end
      if (advance) begin
         out_res_ff <= res;
      end
   end

   // A7 selects the stack pointer by the supervisor bit
   always_comb begin
      if (!in_item_ff.is_address) begin
         slot = {2'b00, in_item_ff.reg_index};
      end else if (in_item_ff.reg_index != SP_REG) begin
         slot = AREG_BASE | {2'b00, in_item_ff.reg_index};
      end else begin
         slot = in_item_ff.supervisor ? SSP_SLOT : USP_SLOT;
      end
   end

   crdo_alu u_alu (
      .item (in_item_ff),
      .cur  (cur),
      .upd  (upd),
      .res  (res)
   );

   always_comb begin
      upd_gated       = upd;
      upd_gated.wr_en = upd.wr_en && advance;
   end

   crdo_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (slot),
      .rd_data (cur),
      .wr_idx  (slot),
      .upd     (upd_gated)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_res_ff};

endmodule

FILE: tb/cpu_register_direct_operand_unit_tb.sv
`timescale 1ns / 100ps

module cpu_register_direct_operand_unit_tb;
   import crdo_pkg::*;

   localparam int unsigned RANDOM_PER_PHASE = 310;
   localparam int unsigned HOLD_CYCLES      = 120;  // long receiver hold-off
   localparam int unsigned DRAIN_CYCLES     = 10;   // drain wait before the final report
   localparam int unsigned STALL_LIMIT      = 4000; // cycles without any beat

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;  // opcode, is_address, reg_index, size_code, operand, supervisor
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // reg_value, zero_flag

   cpu_register_direct_operand_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Register file image: D0-D7 at 0-7, A0-A6 at 8-14, USP at 15, SSP at 16.
   word_type   regfile_image [0:16];
   item_type   pending_items [$];
   result_type expected_results [$];

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned hold_requests     = 0;
   int unsigned holds_served;
   int unsigned hold_left;
   int unsigned quiet_cycles;
   int unsigned mismatch_count    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Predicts one response beat and updates the register image.
   function automatic result_type apply_access(input item_type it);
      result_type  res;
      size_type    sz;
      word_type    mask, cur, nxt, src, src_sext, quick;
      int unsigned slot;
      sz = (it.size_code == SZ_ALT) ? SZ_LONG : it.size_code;
      case (sz)
         SZ_BYTE: mask = 32'h0000_00FF;
         SZ_WORD: mask = 32'h0000_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
      src = it.operand;
      case (sz)
         SZ_BYTE: src_sext = {{24{src[7]}}, src[7:0]};
         SZ_WORD: src_sext = {{16{src[15]}}, src[15:0]};
         default: src_sext = src;
      endcase
      quick = {24'h0, src[7:0]};
      if (!it.is_address)              slot = 32'(it.reg_index);
      else if (it.reg_index != SP_REG) slot = 8 + 32'(it.reg_index);
      else                             slot = it.supervisor ? 16 : 15;
      cur = regfile_image[slot];
      nxt = cur;
      res = '0;
      case (it.opcode)
         OP_READ:  res.reg_value = cur & mask;
         OP_WRITE: begin
            // address-register word writes sign-extend; all else merges
            if (it.is_address && sz == SZ_WORD) nxt = {{16{src[15]}}, src[15:0]};
            else nxt = (cur & ~mask) | (src & mask);
         end
         OP_ADD:   nxt = cur + src;  // always full width
         OP_OR:    nxt = cur | (src & mask);
         OP_SUB: begin
            if (it.is_address) nxt = cur - src_sext;
            else nxt = (cur & ~mask) | ((cur - src) & mask);
         end
         OP_NOT:   nxt = (cur & ~mask) | (~cur & mask);
         OP_SUBQ: begin
            if (it.is_address) nxt = cur - quick;
            else nxt = (cur & ~mask) | ((cur - quick) & mask);
         end
         default:  res.zero_flag = ~cur[src[4:0]];  // bit test, register untouched
      endcase
      regfile_image[slot] = nxt;
      if (it.opcode != OP_READ) res.reg_value = nxt;
      return res;
   endfunction

   function automatic item_type random_access();
      item_type    it;
      int unsigned pick;
      it.opcode     = opcode_type'($urandom_range(0, 7));
      it.is_address = 1'($urandom_range(0, 1));
      it.supervisor = 1'($urandom_range(0, 1));
      // lean on a few registers so results chain, with stack pointers often hit
      pick = $urandom_range(0, 99);
      if (pick < 40) it.reg_index = 3'($urandom_range(0, 1)) + (it.is_address ? 3'd6 : 3'd0);
      else it.reg_index = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      it.size_code = (pick < 8) ? SZ_ALT : size_type'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 45) it.operand = $urandom();
      else if (pick < 70) it.operand = $urandom_range(0, 255);
      else if (pick < 85) begin
         case ($urandom_range(0, 7))
            0: it.operand = 32'h0000_007F;
            1: it.operand = 32'h0000_0080;
            2: it.operand = 32'h0000_00FF;
            3: it.operand = 32'h0000_7FFF;
            4: it.operand = 32'h0000_8000;
            5: it.operand = 32'h0000_FFFF;
            6: it.operand = 32'h8000_0000;
            default: it.operand = 32'hFFFF_FFFF;
         endcase
      end else it.operand = $urandom() | 32'hFFFF_FF00;
      return it;
   endfunction

   task automatic push_access(input opcode_type op, input logic is_a, input logic [2:0] idx,
                              input size_type sz, input word_type val, input logic sup);
      item_type it;
      it.opcode     = op;
      it.is_address = is_a;
      it.reg_index  = idx;
      it.size_code  = sz;
      it.operand    = val;
      it.supervisor = sup;
      pending_items.push_back(it);
   endtask

   // Driver: holds a beat until accepted, predicts on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         foreach (regfile_image[i]) regfile_image[i] = '0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_access(item_type'(req_tdata[41:0])));
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_tdata  <= {6'b0, pending_items.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready: random idling, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         holds_served <= 0;
         hold_left    <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Monitor: compares each response beat with the oldest prediction.
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[32:0]);
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response beat, got %h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.reg_value !== want.reg_value) begin
               $display("%0t: reg_value expected %h got %h", $time, want.reg_value,
                        got.reg_value);
               mismatch_count++;
            end
            if (got.zero_flag !== want.zero_flag) begin
               $display("%0t: zero_flag expected %b got %b", $time, want.zero_flag,
                        got.zero_flag);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("cpu_register_direct_operand_unit_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned phase_idx;
      @(negedge clock);
      for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
         case (phase_idx)
            0: begin
               sender_idle_pct   = 14;
               receiver_idle_pct = 83;
               // sized merges on a data register
               push_access(OP_WRITE, 1'b0, 3'd0, SZ_LONG, 32'hFFFF_FFFF, 1'b0);
               push_access(OP_READ,  1'b0, 3'd0, SZ_BYTE, 32'h0,         1'b0);
               push_access(OP_READ,  1'b0, 3'd0, SZ_WORD, 32'h0,         1'b0);
               push_access(OP_WRITE, 1'b0, 3'd0, SZ_BYTE, 32'h0000_0080, 1'b0);
               push_access(OP_WRITE, 1'b0, 3'd0, SZ_WORD, 32'h5555_1234, 1'b0);
               push_access(OP_READ,  1'b0, 3'd0, SZ_ALT,  32'h0,         1'b1);
               // word writes to address registers sign-extend
               push_access(OP_WRITE, 1'b1, 3'd0, SZ_WORD, 32'h0000_8000, 1'b0);
               push_access(OP_WRITE, 1'b1, 3'd1, SZ_WORD, 32'hFFFF_7FFF, 1'b0);
               // A7 follows the supervisor bit
               push_access(OP_WRITE, 1'b1, 3'd7, SZ_LONG, 32'h0000_2000, 1'b1);
               push_access(OP_WRITE, 1'b1, 3'd7, SZ_LONG, 32'h0000_1000, 1'b0);
               push_access(OP_READ,  1'b1, 3'd7, SZ_LONG, 32'h0,         1'b1);
               push_access(OP_READ,  1'b1, 3'd7, SZ_LONG, 32'h0,         1'b0);
               // add ignores size and wraps
               push_access(OP_ADD,   1'b0, 3'd1, SZ_BYTE, 32'hFFFF_FFFF, 1'b0);
               push_access(OP_ADD,   1'b0, 3'd1, SZ_LONG, 32'h0000_0001, 1'b0);
               push_access(OP_OR,    1'b0, 3'd2, SZ_BYTE, 32'hFFFF_FFFF, 1'b0);
               push_access(OP_SUB,   1'b0, 3'd3, SZ_BYTE, 32'h0000_0001, 1'b0);
               // address subtract: sign-extended source, full width
               push_access(OP_SUB,   1'b1, 3'd2, SZ_BYTE, 32'h0000_0080, 1'b0);
               push_access(OP_SUB,   1'b1, 3'd3, SZ_WORD, 32'h0000_FFFF, 1'b0);
               push_access(OP_SUB,   1'b1, 3'd7, SZ_ALT,  32'h0000_0004, 1'b1);
               push_access(OP_NOT,   1'b0, 3'd4, SZ_WORD, 32'h0,         1'b0);
               push_access(OP_NOT,   1'b1, 3'd4, SZ_BYTE, 32'h0,         1'b0);
               // quick data is the low byte only
               push_access(OP_SUBQ,  1'b0, 3'd5, SZ_BYTE, 32'hFFFF_FF08, 1'b0);
               push_access(OP_SUBQ,  1'b1, 3'd7, SZ_LONG, 32'h1234_5604, 1'b0);
               push_access(OP_SUBQ,  1'b1, 3'd5, SZ_WORD, 32'h0000_0000, 1'b1);
               // bit test: number taken modulo 32, also on an address register
               push_access(OP_BTST,  1'b0, 3'd0, SZ_LONG, 32'hFFFF_FFE0, 1'b0);
               push_access(OP_BTST,  1'b0, 3'd0, SZ_BYTE, 32'h0000_001F, 1'b0);
               push_access(OP_BTST,  1'b1, 3'd0, SZ_WORD, 32'h0000_000F, 1'b0);
            end
            1: begin
               sender_idle_pct   = 83;
               receiver_idle_pct = 14;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) pending_items.push_back(random_access());
         // sender keeps offering while the receiver holds off: fills the pipe
         if (phase_idx == 2) hold_requests++;
         while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0)
            @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cpu_register_direct_operand_unit_tb: done, clean");
      end else begin
         $display("cpu_register_direct_operand_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
